FILE: src/itaf_pkg.sv
// Shared types and constants for the integer-to-ASCII formatter.
// Holds mode codes, ASCII codes, the controller/datapath command and status
// structs, and the digit-to-character function. No dependencies.
`default_nettype none

package itaf_pkg;

    // Format mode codes
    localparam logic [2:0] MODE_SDEC = 3'd0;
    localparam logic [2:0] MODE_UDEC = 3'd1;
    localparam logic [2:0] MODE_HEXL = 3'd2;
    localparam logic [2:0] MODE_HEXU = 3'd3;
    localparam logic [2:0] MODE_PTR  = 3'd4;

    // Digit buffer geometry
    localparam int unsigned NUM_DIGITS = 16;
    localparam int unsigned DEC_DIGITS = 10;
    localparam int unsigned HEX_DIGITS = 8;
    localparam int unsigned BIN_BITS   = 32;

    // ASCII codes
    localparam logic [7:0] ASC_ZERO  = 8'h30;
    localparam logic [7:0] ASC_LOWA  = 8'h61;
    localparam logic [7:0] ASC_UPA   = 8'h41;
    localparam logic [7:0] ASC_MINUS = 8'h2D;
    localparam logic [7:0] ASC_X     = 8'h78;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture a new transaction
        logic dabble;   // one shift-and-adjust step of binary to BCD
        logic strip;    // drop one leading zero digit
        logic emit;     // load the output register and advance
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic strip_done;   // top digit nonzero or only one digit left
        logic emit_last;    // current character is the final one
    } t_sts;

    // Map one digit (0..15) to its ASCII code
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        begin
            base = upper ? ASC_UPA : ASC_LOWA;
            if (d < 4'd10) begin
                digit_char = ASC_ZERO + {4'd0, d};
            end else begin
                digit_char = base + {4'd0, d} - 8'd10;
            end
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/itaf_ctrl.sv
// Controller state machine of the integer-to-ASCII formatter.
// Sequences load, binary-to-BCD conversion, zero stripping and emission.
// Depends on itaf_pkg.
`default_nettype none

module itaf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [2:0]    i_mode,
    output logic               o_ready,
    output logic               o_valid,
    input  wire logic          i_ready,
    output itaf_pkg::t_cmd     o_cmd,
    input  wire itaf_pkg::t_sts i_sts
);
    import itaf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DAB,
        S_STRIP,
        S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic       accept, mode_ok, is_dec;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign accept  = i_valid && o_ready;
    assign mode_ok = (i_mode <= MODE_PTR);
    assign is_dec  = (i_mode == MODE_SDEC) || (i_mode == MODE_UDEC);

    // Next state, commands and output-register valid
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd       = '0;
        o_cmd.emit  = 1'b0;
        n_out_valid = (r_out_valid && !i_ready) ? 1'b1 : 1'b0;
        case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (accept && mode_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = is_dec ? S_DAB : S_STRIP;
                end
            end
            S_DAB: begin
                o_cmd.dabble = 1'b1;
                n_step       = r_step + 5'd1;
                if (r_step == 5'(BIN_BITS - 1)) begin
                    n_state = S_STRIP;
                end
            end
            S_STRIP: begin
                if (i_sts.strip_done) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.strip = 1'b1;
                end
            end
            S_EMIT: begin
                // Advance when the output register is free or being drained
                if (!r_out_valid || i_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

FILE: src/itaf_dpath.sv
// Datapath of the integer-to-ASCII formatter: digit buffer, double-dabble
// step, leading-zero strip, character selection and output register.
// Depends on itaf_pkg.
`default_nettype none

module itaf_dpath (
    input  wire logic           i_clk,
    input  wire itaf_pkg::t_cmd i_cmd,
    input  wire logic [2:0]     i_mode,
    input  wire logic [63:0]    i_value,
    output itaf_pkg::t_sts      o_sts,
    output logic [7:0]          o_character,
    output logic                o_last,
    output logic [4:0]          o_char_count
);
    import itaf_pkg::*;

    logic [NUM_DIGITS-1:0][3:0] r_digits, n_digits;
    logic [BIN_BITS-1:0]        r_bin, n_bin;
    logic [4:0]                 r_ndig, n_ndig;
    logic [1:0]                 r_pre, n_pre;
    logic [4:0]                 r_total, n_total;
    logic                       r_upper, n_upper;
    logic                       r_ptr, n_ptr;
    logic [7:0]                 r_char;
    logic                       r_last;
    logic [4:0]                 r_count;

    logic [31:0]                low, mag;
    logic                       neg;
    logic [3:0]                 top_idx;
    logic [3:0]                 top_digit;
    logic [DEC_DIGITS-1:0][3:0] adj;
    logic [7:0]                 cur_char;
    logic                       cur_last;

    assign low       = i_value[31:0];
    assign neg       = (i_mode == MODE_SDEC) && low[31];
    assign mag       = neg ? (~low + 32'd1) : low;
    assign top_idx   = 4'(r_ndig - 5'd1);
    assign top_digit = r_digits[top_idx];

    // Add 3 to every BCD digit of 5 or more before the shift
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            adj[i] = (r_digits[i] >= 4'd5) ? (r_digits[i] + 4'd3) : r_digits[i];
        end
    end

    // Select the current character: prefix first, then digits
    always_comb begin
        if (r_pre != 2'd0) begin
            if (r_ptr) begin
                cur_char = (r_pre == 2'd2) ? ASC_ZERO : ASC_X;
            end else begin
                cur_char = ASC_MINUS;
            end
        end else begin
            cur_char = digit_char(top_digit, r_upper);
        end
        cur_last = (r_pre == 2'd0) && (r_ndig == 5'd1);
    end

    assign o_sts.strip_done = (r_ndig == 5'd1) || (top_digit != 4'd0);
    assign o_sts.emit_last  = cur_last;

    // Next values of the working registers
    always_comb begin
        n_digits = r_digits;
        n_bin    = r_bin;
        n_ndig   = r_ndig;
        n_pre    = r_pre;
        n_total  = r_total;
        n_upper  = r_upper;
        n_ptr    = r_ptr;
        if (i_cmd.load) begin
            n_upper = (i_mode == MODE_HEXU);
            n_ptr   = (i_mode == MODE_PTR);
            n_bin   = mag;
            case (i_mode)
                MODE_SDEC, MODE_UDEC: begin
                    n_digits = '0;
                    n_ndig   = 5'(DEC_DIGITS);
                    n_pre    = neg ? 2'd1 : 2'd0;
                end
                MODE_HEXL, MODE_HEXU: begin
                    n_digits = {32'd0, low};
                    n_ndig   = 5'(HEX_DIGITS);
                    n_pre    = 2'd0;
                end
                MODE_PTR: begin
                    n_digits = i_value;
                    n_ndig   = 5'(NUM_DIGITS);
                    n_pre    = 2'd2;
                end
                default: begin
                    n_digits = '0;
                    n_ndig   = 5'd1;
                    n_pre    = 2'd0;
                end
            endcase
            n_total = n_ndig + {3'd0, n_pre};
        end else if (i_cmd.dabble) begin
            // Shift the BCD digits left one bit; the top digit never exceeds 4
            n_digits[DEC_DIGITS-1:0] = {adj[DEC_DIGITS-1][2:0], adj[DEC_DIGITS-2:0],
                                        r_bin[BIN_BITS-1]};
            n_bin                    = {r_bin[BIN_BITS-2:0], 1'b0};
        end else if (i_cmd.strip) begin
            n_ndig  = r_ndig - 5'd1;
            n_total = r_total - 5'd1;
        end else if (i_cmd.emit) begin
            if (r_pre != 2'd0) begin
                n_pre = r_pre - 2'd1;
            end else begin
                n_ndig = r_ndig - 5'd1;
            end
        end
    end

    // Hold working registers and the output register
    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_bin    <= n_bin;
        r_ndig   <= n_ndig;
        r_pre    <= n_pre;
        r_total  <= n_total;
        r_upper  <= n_upper;
        r_ptr    <= n_ptr;
        if (i_cmd.emit) begin
            r_char  <= cur_char;
            r_last  <= cur_last;
            r_count <= cur_last ? r_total : 5'd0;
        end
    end

    assign o_character  = r_char;
    assign o_last       = r_last;
    assign o_char_count = r_count;

endmodule

`default_nettype wire

FILE: src/integer_to_ascii_formatter_unit.sv
// Top level of the integer-to-ASCII formatter.
// Instantiates itaf_ctrl and itaf_dpath; depends on itaf_pkg.
//
//  channel | signals                                   | dir | meaning
//  --------+-------------------------------------------+-----+---------------------------
//  input   | i_valid, o_ready, i_mode, i_value         | in  | one value and format mode
//  output  | o_valid, i_ready, o_character, o_last,    | out | one ASCII character per
//          | o_char_count                              |     | transfer
//
// Steps: a decimal value takes a load, 32 double-dabble steps, one strip per dropped
// leading zero, a check of the top digit and one emit per character; dropped zeros and
// characters together cover 10 digits plus the sign.
// Hex takes a load, the strips, the check and the emits, with no double-dabble steps;
// dropped zeros and characters cover 8 digits, or 16 digits plus the 0x prefix for a pointer.
// Modes 5 to 7 are accepted and give no characters.
// Reset (synchronous, active low) returns the controller to idle and empties the
// output register. A stalled output holds the character and pauses emission.
`default_nettype none

module integer_to_ascii_formatter_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_mode,
    input  wire logic [63:0] i_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_character,
    output logic             o_last,
    output logic [4:0]       o_char_count
);
    import itaf_pkg::*;

    t_cmd cmd;
    t_sts sts;

    itaf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_mode  (i_mode),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    itaf_dpath u_dpath (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_mode       (i_mode),
        .i_value      (i_value),
        .o_sts        (sts),
        .o_character  (o_character),
        .o_last       (o_last),
        .o_char_count (o_char_count)
    );

endmodule

`default_nettype wire
